// File: hw/rtl/i2cgx_pkg.sv
`default_nettype none

package i2cgx_pkg;

	// item opcodes; codes 6 and 7 are unused
	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_SETUP    = 3'd1,
		OP_WRITE    = 3'd2,
		OP_TOGGLE   = 3'd3,
		OP_READ_IN  = 3'd4,
		OP_READ_OUT = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_RSEL  = 3'd1,
		PH_RRECV = 3'd2,
		PH_RDONE = 3'd3,
		PH_WSEL  = 3'd4,
		PH_WDATA = 3'd5,
		PH_WDONE = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		MSG_STOP  = 3'd0,
		MSG_RSEL  = 3'd1,
		MSG_RDATA = 3'd2,
		MSG_WSEL  = 3'd3,
		MSG_WDATA = 3'd4
	} kind_t;

	typedef struct packed {
		logic sync_w;
		logic sync_r;
		logic restart;
		logic awaiting;
		logic send;
	} flags_t;

	// register pair numbers of the device (pair n = registers 2n, 2n+1)
	localparam logic [1:0] PAIR_IN  = 2'd0;
	localparam logic [1:0] PAIR_OUT = 2'd1;
	localparam logic [1:0] PAIR_POL = 2'd2;
	localparam logic [1:0] PAIR_DIR = 2'd3;

	localparam logic [6:0]  DEV_ADDR_RST   = 7'd32;
	localparam logic [2:0]  WR_INDEX_FIRST = 3'd2;
	localparam logic [2:0]  RD_INDEX_FIRST = 3'd0;
	localparam logic [15:0] ONES_RST       = 16'hffff;
	localparam logic [15:0] ZEROS_RST      = 16'h0000;

	typedef struct packed {
		logic [2:0] opcode;
		logic [3:0] pin;
		logic       pin_mode;
		logic       pin_output;
		logic       pin_polarity;
		logic       level;
		logic       xfer_accepted;
		logic       xfer_done;
		logic       xfer_fault;
		logic [7:0] rx_byte0;
		logic [7:0] rx_byte1;
		logic       module_faulted;
	} req_t;

	// bus message part of a result
	typedef struct packed {
		logic       xfer_offer;
		logic [1:0] xfer_length;
		logic       flag_start;
		logic       flag_address;
		logic       flag_read;
		logic       flag_nack_last;
		logic       flag_stop;
		logic [7:0] tx_byte0;
		logic [7:0] tx_byte1;
		logic [6:0] slave_address;
	} msg_t;

	typedef struct packed {
		logic       xfer_offer;
		logic [1:0] xfer_length;
		logic       flag_start;
		logic       flag_address;
		logic       flag_read;
		logic       flag_nack_last;
		logic       flag_stop;
		logic [7:0] tx_byte0;
		logic [7:0] tx_byte1;
		logic [6:0] slave_address;
		logic       pin_level;
		logic       busy_res;
	} rsp_t;

	// shadow pair addressed by a write index: 0 out, 1 polarity, 2 direction
	function automatic logic [1:0] wr_pair(input logic [2:0] wi);
		logic [1:0] p;
		p = (wi[2:1] == 2'd0) ? 2'd0 : wi[2:1] - 2'd1;
		return p;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/i2cgx_if.sv
`default_nettype none

interface i2cgx_req_if;
	logic                valid;
	logic                ready;
	i2cgx_pkg::req_t     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface i2cgx_rsp_if;
	logic                valid;
	logic                ready;
	i2cgx_pkg::rsp_t     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface i2cgx_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/i2cgx_msg.sv
`default_nettype none

// formats the offered bus message; all zero when nothing is offered
module i2cgx_msg (
	input  logic               offer,
	input  i2cgx_pkg::kind_t   kind,
	input  logic [2:0]         rd_index,
	input  logic [2:0]         wr_index,
	input  logic [6:0]         dev_addr,
	input  logic [15:0]        sh_out,
	input  logic [15:0]        sh_pol,
	input  logic [15:0]        sh_dir,
	output i2cgx_pkg::msg_t    msg
);

	logic [15:0] wr_data;

	always_comb begin
		unique case (i2cgx_pkg::wr_pair(wr_index))
			2'd0:    wr_data = sh_out;
			2'd1:    wr_data = sh_pol;
			default: wr_data = sh_dir;
		endcase
	end

	always_comb begin
		msg = '0;
		if (offer) begin
			msg.xfer_offer    = 1'b1;
			msg.slave_address = dev_addr;
			unique case (kind)
				i2cgx_pkg::MSG_RSEL: begin
					msg.xfer_length  = 2'd1;
					msg.flag_start   = 1'b1;
					msg.flag_address = 1'b1;
					msg.tx_byte0     = {5'd0, rd_index};
				end
				i2cgx_pkg::MSG_RDATA: begin
					msg.xfer_length    = 2'd2;
					msg.flag_start     = 1'b1;
					msg.flag_address   = 1'b1;
					msg.flag_read      = 1'b1;
					msg.flag_nack_last = 1'b1;
					msg.flag_stop      = 1'b1;
				end
				i2cgx_pkg::MSG_WSEL: begin
					msg.xfer_length  = 2'd1;
					msg.flag_start   = 1'b1;
					msg.flag_address = 1'b1;
					msg.tx_byte0     = {5'd0, wr_index};
				end
				i2cgx_pkg::MSG_WDATA: begin
					msg.xfer_length = 2'd2;
					msg.flag_stop   = 1'b1;
					msg.tx_byte0    = wr_data[7:0];
					msg.tx_byte1    = wr_data[15:8];
				end
				default: begin
					msg.flag_stop = 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/i2c_gpio_expander_sync_sequencer.sv
`default_nettype none

// Register-sync sequencer for a 16-bit I2C port expander. Every request is
// one tick, pin set-up, pin write, pin toggle or pin read, and gives exactly
// one result in the cycle after it is accepted. A new request is taken every
// cycle; req.ready drops only while the result register is full and rsp.ready
// is low. The device mirror (input, output, polarity, direction pairs) and
// the user shadow (output, polarity, direction) sit in flip-flops, so all
// decode, pin access and sequencer stepping is one short combinational pass
// between the request handshake and the result register. The slave address
// register (reset 32) is written over cfg, which is always ready; the user
// must change it only while no request is in flight; the block does not enforce it.
module i2c_gpio_expander_sync_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	i2cgx_req_if.sink   req,
	i2cgx_rsp_if.source rsp,
	i2cgx_cfg_if.sink   cfg
);

	// ---------------------------------------------------------------- state
	logic [6:0]          dev_addr_q;
	i2cgx_pkg::phase_t   phase_q;
	i2cgx_pkg::flags_t   flags_q;
	logic [2:0]          ri_q;
	logic [2:0]          wi_q;
	i2cgx_pkg::kind_t    kind_q;
	logic                lf_q;      // fault latched at last completion

	// device mirror
	logic [15:0] mir_in_q, mir_out_q, mir_pol_q, mir_dir_q;
	// user shadow
	logic [15:0] sh_out_q, sh_pol_q, sh_dir_q;

	logic            rsp_valid_q;
	i2cgx_pkg::rsp_t rsp_data_q;

	// ---------------------------------------------------------------- handshake
	logic accept;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// ---------------------------------------------------------------- restart step
	// A tick with restart pending first queues a stop-only message and
	// rewinds the interrupted direction to its first pair.
	logic              is_tick;
	i2cgx_pkg::phase_t p_phase;
	i2cgx_pkg::flags_t p_flags;
	logic [2:0]        p_ri, p_wi;
	i2cgx_pkg::kind_t  p_kind;

	assign is_tick = (req.data.opcode == i2cgx_pkg::OP_TICK);

	always_comb begin
		p_phase = phase_q;
		p_flags = flags_q;
		p_ri    = ri_q;
		p_wi    = wi_q;
		p_kind  = kind_q;
		if (is_tick && flags_q.restart) begin
			p_kind          = i2cgx_pkg::MSG_STOP;
			p_flags.send    = 1'b1;
			p_flags.restart = 1'b0;
			if (phase_q == i2cgx_pkg::PH_WSEL || phase_q == i2cgx_pkg::PH_WDATA ||
				phase_q == i2cgx_pkg::PH_WDONE) begin
				p_wi    = i2cgx_pkg::WR_INDEX_FIRST;
				p_phase = i2cgx_pkg::PH_WSEL;
			end else if (phase_q == i2cgx_pkg::PH_RSEL || phase_q == i2cgx_pkg::PH_RRECV ||
				phase_q == i2cgx_pkg::PH_RDONE) begin
				p_ri    = i2cgx_pkg::RD_INDEX_FIRST;
				p_phase = i2cgx_pkg::PH_RSEL;
			end
		end
	end

	// ---------------------------------------------------------------- message
	i2cgx_pkg::msg_t msg;

	i2cgx_msg u_msg (
		.offer    (is_tick && p_flags.send),
		.kind     (p_kind),
		.rd_index (p_ri),
		.wr_index (p_wi),
		.dev_addr (dev_addr_q),
		.sh_out   (sh_out_q),
		.sh_pol   (sh_pol_q),
		.sh_dir   (sh_dir_q),
		.msg      (msg)
	);

	// ---------------------------------------------------------------- next state
	i2cgx_pkg::phase_t n_phase;
	i2cgx_pkg::flags_t n_flags;
	logic [2:0]        n_ri, n_wi;
	logic              n_lf;
	logic [15:0]       n_sh_out, n_sh_pol, n_sh_dir;
	logic              mir_we;
	logic [1:0]        mir_sel;
	logic              pin_lvl;
	logic [15:0]       pin_mask;
	logic [2:0]        ri_inc;
	logic [1:0]        wpair;
	i2cgx_pkg::rsp_t   rsp_next;

	assign pin_mask = 16'd1 << req.data.pin;
	assign ri_inc   = p_ri + 3'd2;
	assign wpair    = i2cgx_pkg::wr_pair(p_wi);

	always_comb begin
		n_phase  = p_phase;
		n_flags  = p_flags;
		n_ri     = p_ri;
		n_wi     = p_wi;
		n_lf     = lf_q;
		n_sh_out = sh_out_q;
		n_sh_pol = sh_pol_q;
		n_sh_dir = sh_dir_q;
		mir_we   = 1'b0;
		mir_sel  = p_ri[2:1];
		pin_lvl  = 1'b0;
		unique case (i2cgx_pkg::op_t'(req.data.opcode))
			i2cgx_pkg::OP_TICK: begin
				if (p_flags.send) begin
					if (req.data.xfer_accepted) begin
						n_flags.send     = 1'b0;
						n_flags.awaiting = 1'b1;
					end
				end else if (p_flags.awaiting) begin
					if (req.data.xfer_done) begin
						n_flags.awaiting = 1'b0;
						n_lf             = req.data.xfer_fault;
						// good read-back lands in the mirror
						mir_we = (p_kind == i2cgx_pkg::MSG_RDATA) && !req.data.xfer_fault;
					end
				end else begin
					unique case (p_phase)
						i2cgx_pkg::PH_RSEL: begin
							n_flags.send = 1'b1;
							n_phase      = i2cgx_pkg::PH_RRECV;
						end
						i2cgx_pkg::PH_RRECV: begin
							if (lf_q) n_flags.restart = 1'b1;
							else begin
								n_flags.send = 1'b1;
								n_phase      = i2cgx_pkg::PH_RDONE;
							end
						end
						i2cgx_pkg::PH_RDONE: begin
							if (lf_q) n_flags.restart = 1'b1;
							else if (ri_inc[2:1] == 2'd0) begin
								n_phase = i2cgx_pkg::PH_IDLE;
								n_ri    = i2cgx_pkg::RD_INDEX_FIRST;
							end else begin
								n_ri    = ri_inc;
								n_phase = i2cgx_pkg::PH_RSEL;
							end
						end
						i2cgx_pkg::PH_WSEL: begin
							n_flags.send = 1'b1;
							n_phase      = i2cgx_pkg::PH_WDATA;
						end
						i2cgx_pkg::PH_WDATA: begin
							if (lf_q) n_flags.restart = 1'b1;
							else begin
								n_flags.send = 1'b1;
								n_phase      = i2cgx_pkg::PH_WDONE;
							end
						end
						i2cgx_pkg::PH_WDONE: begin
							if (lf_q) n_flags.restart = 1'b1;
							else if (wpair == 2'd2) begin
								// all three pairs written: schedule read-back
								n_flags.sync_r = 1'b1;
								n_phase        = i2cgx_pkg::PH_IDLE;
								n_wi           = i2cgx_pkg::WR_INDEX_FIRST;
							end else begin
								n_wi    = {wpair + 2'd2, 1'b0};
								n_phase = i2cgx_pkg::PH_WSEL;
							end
						end
						default: begin
							if (p_flags.sync_r) begin
								n_phase        = i2cgx_pkg::PH_RSEL;
								n_flags.sync_r = 1'b0;
							end else if (p_flags.sync_w) begin
								n_phase        = i2cgx_pkg::PH_WSEL;
								n_flags.sync_w = 1'b0;
							end
						end
					endcase
				end
			end
			i2cgx_pkg::OP_SETUP: begin
				n_sh_dir = (sh_dir_q & ~pin_mask) | ({16{req.data.pin_mode}} & pin_mask);
				n_sh_out = (sh_out_q & ~pin_mask) | ({16{req.data.pin_output}} & pin_mask);
				n_sh_pol = (sh_pol_q & ~pin_mask) | ({16{req.data.pin_polarity}} & pin_mask);
				n_flags.sync_w = 1'b1;
			end
			i2cgx_pkg::OP_WRITE: begin
				// sync only when the pin actually changes
				if (!req.data.module_faulted && sh_out_q[req.data.pin] != req.data.level) begin
					n_sh_out       = sh_out_q ^ pin_mask;
					n_flags.sync_w = 1'b1;
				end
			end
			i2cgx_pkg::OP_TOGGLE: begin
				if (!req.data.module_faulted) begin
					n_sh_out       = sh_out_q ^ pin_mask;
					n_flags.sync_w = 1'b1;
				end
			end
			i2cgx_pkg::OP_READ_IN: begin
				pin_lvl = !req.data.module_faulted && mir_in_q[req.data.pin];
			end
			i2cgx_pkg::OP_READ_OUT: begin
				pin_lvl = !req.data.module_faulted && mir_out_q[req.data.pin];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		rsp_next.xfer_offer     = msg.xfer_offer;
		rsp_next.xfer_length    = msg.xfer_length;
		rsp_next.flag_start     = msg.flag_start;
		rsp_next.flag_address   = msg.flag_address;
		rsp_next.flag_read      = msg.flag_read;
		rsp_next.flag_nack_last = msg.flag_nack_last;
		rsp_next.flag_stop      = msg.flag_stop;
		rsp_next.tx_byte0       = msg.tx_byte0;
		rsp_next.tx_byte1       = msg.tx_byte1;
		rsp_next.slave_address  = msg.slave_address;
		rsp_next.pin_level      = pin_lvl;
		rsp_next.busy_res       = (n_phase != i2cgx_pkg::PH_IDLE) || (|n_flags);
	end

	// ---------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= i2cgx_pkg::DEV_ADDR_RST;
		end else if (cfg.valid) begin
			dev_addr_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= i2cgx_pkg::PH_IDLE;
			flags_q   <= '{sync_r: 1'b1, default: 1'b0};
			ri_q      <= i2cgx_pkg::RD_INDEX_FIRST;
			wi_q      <= i2cgx_pkg::WR_INDEX_FIRST;
			kind_q    <= i2cgx_pkg::MSG_STOP;
			lf_q      <= 1'b0;
			sh_out_q  <= i2cgx_pkg::ONES_RST;
			sh_pol_q  <= i2cgx_pkg::ZEROS_RST;
			sh_dir_q  <= i2cgx_pkg::ONES_RST;
		end else if (accept) begin
			phase_q  <= n_phase;
			flags_q  <= n_flags;
			ri_q     <= n_ri;
			wi_q     <= n_wi;
			lf_q     <= n_lf;
			sh_out_q <= n_sh_out;
			sh_pol_q <= n_sh_pol;
			sh_dir_q <= n_sh_dir;
			// a queued message takes the kind that fits the phase it leaves
			if (is_tick && !p_flags.send && !p_flags.awaiting && n_flags.send) begin
				unique case (p_phase)
					i2cgx_pkg::PH_RSEL:  kind_q <= i2cgx_pkg::MSG_RSEL;
					i2cgx_pkg::PH_RRECV: kind_q <= i2cgx_pkg::MSG_RDATA;
					i2cgx_pkg::PH_WSEL:  kind_q <= i2cgx_pkg::MSG_WSEL;
					default:             kind_q <= i2cgx_pkg::MSG_WDATA;
				endcase
			end else begin
				kind_q <= p_kind;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mir_in_q  <= i2cgx_pkg::ZEROS_RST;
			mir_out_q <= i2cgx_pkg::ONES_RST;
			mir_pol_q <= i2cgx_pkg::ZEROS_RST;
			mir_dir_q <= i2cgx_pkg::ONES_RST;
		end else if (accept && mir_we) begin
			unique case (mir_sel)
				i2cgx_pkg::PAIR_IN:  mir_in_q  <= {req.data.rx_byte1, req.data.rx_byte0};
				i2cgx_pkg::PAIR_OUT: mir_out_q <= {req.data.rx_byte1, req.data.rx_byte0};
				i2cgx_pkg::PAIR_POL: mir_pol_q <= {req.data.rx_byte1, req.data.rx_byte0};
				default:             mir_dir_q <= {req.data.rx_byte1, req.data.rx_byte0};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_data_q <= rsp_next;
		end
	end

`ifndef SYNTHESIS
	// a message is never offered and awaited at once
	a_send_await: assert property (@(posedge clk) disable iff (!arst_n)
		!(flags_q.send && flags_q.awaiting))
		else $error("send and await both pending");

	// pair indexes stay on even register numbers
	a_index_even: assert property (@(posedge clk) disable iff (!arst_n)
		!ri_q[0] && (wi_q == 3'd2 || wi_q == 3'd4 || wi_q == 3'd6))
		else $error("sequencer index off pair boundary");

	// a result without an offer carries no message
	a_quiet_msg: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_data_q.xfer_offer |->
		rsp_data_q.xfer_length == 2'd0 && !rsp_data_q.flag_stop &&
		rsp_data_q.slave_address == 7'd0)
		else $error("message fields set without offer");

	// every accepted request leaves a result behind
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q)
		else $error("accepted request produced no result");
`endif

endmodule

`default_nettype wire
